// ----- rtl/f2dt_pkg.sv -----
// Package for float_to_decimal_text: types, character codes and elaboration helpers.
package f2dt_pkg;

   localparam int DEF_FRACTION_DIGITS = 6;
   localparam int MAX_CHARS           = 18;
   localparam int WHOLE_DIGITS        = 10;
   localparam int CNT_W               = $clog2(MAX_CHARS + 1);
   localparam int WIDX_W              = $clog2(WHOLE_DIGITS + 1);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam logic [7:0]  EXP_SPECIAL   = 8'hFF;
   localparam logic [7:0]  EXP_SAT_MIN   = 8'd159;
   localparam logic [7:0]  EXP_INT_MIN   = 8'd150;
   localparam logic [7:0]  RSH_SUBNORMAL = 8'd149;
   localparam logic [63:0] RECIP_TEN     = 64'h0000_0000_CCCC_CCCD;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_SHIFT,
      ST_WHOLE_DIG,
      ST_FRAC_DIG,
      ST_SIGN,
      ST_WHOLE_OUT,
      ST_DOT,
      ST_FRAC_OUT
   } state_type;

   // digit count held to 1..9
   function automatic int clamp_digits(input int d);
      int r;
      r = d;
      if (r < 1) r = 1;
      if (r > 9) r = 9;
      return r;
   endfunction

   function automatic logic [31:0] pow10(input int d);
      logic [31:0] p;
      p = 32'd1;
      for (int i = 0; i < d; i++) p = p * 32'd10;
      return p;
   endfunction

endpackage

// ----- rtl/float_to_decimal_text_top.sv -----
// Top level: single-precision float bits to a stream of ASCII decimal characters.
//
// Usage
//   Input channel req_*: one transfer carries the 32 bits of an IEEE single
//   precision value. req_stall is high while a value is being converted or
//   its text is still being issued, so one value is in work at a time.
//   Result channel rsp_*: one transfer per character ('-', digits, '.'),
//   rsp_last_char marks the final character of a value's text and
//   rsp_saturated is set on every character of a text whose whole part
//   clipped to 4294967295 (infinity, NaN, magnitude of 2^32 or more).
//   Flow: after the input transfer, the PREP, MUL and SHIFT states unpack
//   the value, multiply the fraction bits by 10^FRACTION_DIGITS and align
//   the product; then one shared divide-by-ten unit (reciprocal multiply)
//   yields one digit a cycle, 1 to 10 for the whole part and FRACTION_DIGITS
//   (held to 1..9) for the fraction. Characters then leave at one per cycle
//   while the result channel does not stall, at most 18 of them.
//   Stall: a stalled result sits in the output register; issue pauses and
//   resumes with no loss. A new value may be taken while the last character
//   of the previous one still waits in that register.
//   Reset: synchronous, active high; returns to idle with no result pending.
module float_to_decimal_text_top
   import f2dt_pkg::*;
#(
   parameter int FRACTION_DIGITS = DEF_FRACTION_DIGITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_char,
   output logic        rsp_saturated
);

   // Effective digit count and derived widths
   localparam int          D      = clamp_digits(FRACTION_DIGITS);
   localparam logic [31:0] PW     = pow10(D);
   localparam int          PW_W   = $clog2(PW + 1);
   localparam int          PROD_W = 24 + PW_W;
   localparam int          FW     = $clog2(D + 1);
   localparam int          FIW    = (D > 1) ? $clog2(D) : 1;

   state_type state_ff, state_in;

   logic [31:0]       val_ff, val_in;
   logic              neg_ff, neg_in;
   logic              sat_ff, sat_in;
   logic [23:0]       low_ff, low_in;
   logic [7:0]        rsh_ff, rsh_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PW_W-1:0]   fdig_ff, fdig_in;
   logic [31:0]       work_ff, work_in;

   logic [3:0]        wbuf_ff [WHOLE_DIGITS];
   logic [3:0]        wbuf_in [WHOLE_DIGITS];
   logic [3:0]        fbuf_ff [D];
   logic [3:0]        fbuf_in [D];
   logic [WIDX_W-1:0] wi_ff, wi_in;   // whole digit count / issue index
   logic [FW-1:0]     fi_ff, fi_in;   // fraction digit index
   logic [FW-1:0]     keep_ff, keep_in;
   logic              found_ff, found_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_sat_ff, rsp_sat_in;

   // Shared divide-by-ten unit
   logic [63:0] div_prod;
   logic [31:0] div_q;
   logic [31:0] div_qx10;
   logic [31:0] div_rem;
   logic [3:0]  div_r;

   assign div_prod = {32'd0, work_ff} * RECIP_TEN;
   assign div_q    = {3'd0, div_prod[63:35]};
   assign div_qx10 = (div_q << 3) + (div_q << 1);
   assign div_rem  = work_ff - div_qx10;
   assign div_r    = div_rem[3:0];

   // Unpacking of the captured value
   logic [7:0]  expo;
   logic [22:0] mant;
   logic [23:0] sig;
   logic [7:0]  lsh;

   assign expo = val_ff[30:23];
   assign mant = val_ff[22:0];
   assign sig  = (expo == 8'd0) ? {1'b0, mant} : {1'b1, mant};
   assign lsh  = expo - EXP_INT_MIN;

   logic can_load;
   logic at_limit;

   assign can_load = !rsp_valid_ff || !rsp_stall;
   assign at_limit = (cnt_ff == CNT_W'(MAX_CHARS - 1));

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      low_in       = low_ff;
      rsh_in       = rsh_ff;
      prod_in      = prod_ff;
      fdig_in      = fdig_ff;
      work_in      = work_ff;
      wbuf_in      = wbuf_ff;
      fbuf_in      = fbuf_ff;
      wi_in        = wi_ff;
      fi_in        = fi_ff;
      keep_in      = keep_ff;
      found_in     = found_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_sat_in   = rsp_sat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in   = req_value_bits;
               state_in = ST_PREP;
            end
         end

         ST_PREP: begin
            // NaN and zero of either sign print without '-'
            neg_in = val_ff[31] && !(expo == EXP_SPECIAL && mant != 23'd0)
                     && (val_ff[30:0] != 31'd0);
            sat_in = 1'b0;
            rsh_in = (expo == 8'd0) ? RSH_SUBNORMAL : (EXP_INT_MIN - expo);
            if (expo == EXP_SPECIAL || expo >= EXP_SAT_MIN) begin
               sat_in  = 1'b1;
               work_in = 32'hFFFF_FFFF;
               low_in  = 24'd0;
            end else if (expo >= EXP_INT_MIN) begin
               work_in = {8'd0, sig} << lsh[3:0];
               low_in  = 24'd0;
            end else if (rsh_in >= 8'd24) begin
               work_in = 32'd0;
               low_in  = sig;
            end else begin
               work_in = {8'd0, sig >> rsh_in[4:0]};
               low_in  = sig & ~({24{1'b1}} << rsh_in[4:0]);
            end
            state_in = ST_MUL;
         end

         ST_MUL: begin
            prod_in  = PROD_W'(low_ff) * PROD_W'(PW);
            state_in = ST_SHIFT;
         end

         ST_SHIFT: begin
            if (rsh_ff >= 8'd64) begin
               fdig_in = '0;
            end else begin
               fdig_in = PW_W'(prod_ff >> rsh_ff[5:0]);
            end
            wi_in    = '0;
            state_in = ST_WHOLE_DIG;
         end

         ST_WHOLE_DIG: begin
            // least significant digit first
            wbuf_in[wi_ff] = div_r;
            wi_in          = wi_ff + 1'b1;
            work_in        = div_q;
            if (div_q == 32'd0 || wi_ff == WIDX_W'(WHOLE_DIGITS - 1)) begin
               work_in  = {{(32 - PW_W){1'b0}}, fdig_ff};
               fi_in    = FW'(D - 1);
               keep_in  = FW'(1);
               found_in = 1'b0;
               state_in = ST_FRAC_DIG;
            end
         end

         ST_FRAC_DIG: begin
            fbuf_in[fi_ff[FIW-1:0]] = div_r;
            work_in                 = div_q;
            // last non-zero digit sets the kept length
            if (div_r != 4'd0 && !found_ff) begin
               keep_in  = fi_ff + 1'b1;
               found_in = 1'b1;
            end
            if (fi_ff == '0) begin
               wi_in    = wi_ff - 1'b1;
               cnt_in   = '0;
               state_in = neg_ff ? ST_SIGN : ST_WHOLE_OUT;
            end else begin
               fi_in = fi_ff - 1'b1;
            end
         end

         ST_SIGN: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               rsp_sat_in   = sat_ff;
               cnt_in       = cnt_ff + 1'b1;
               state_in     = ST_WHOLE_OUT;
            end
         end

         ST_WHOLE_OUT: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO + {4'd0, wbuf_ff[wi_ff]};
               rsp_last_in  = at_limit;
               rsp_sat_in   = sat_ff;
               cnt_in       = cnt_ff + 1'b1;
               if (at_limit) begin
                  state_in = ST_IDLE;
               end else if (wi_ff == '0) begin
                  state_in = ST_DOT;
               end else begin
                  wi_in = wi_ff - 1'b1;
               end
            end
         end

         ST_DOT: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_DOT;
               rsp_last_in  = at_limit;
               rsp_sat_in   = sat_ff;
               cnt_in       = cnt_ff + 1'b1;
               fi_in        = '0;
               state_in     = at_limit ? ST_IDLE : ST_FRAC_OUT;
            end
         end

         ST_FRAC_OUT: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO + {4'd0, fbuf_ff[fi_ff[FIW-1:0]]};
               rsp_sat_in   = sat_ff;
               cnt_in       = cnt_ff + 1'b1;
               if (at_limit || fi_ff == keep_ff - 1'b1) begin
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  rsp_last_in = 1'b0;
                  fi_in       = fi_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      neg_ff      <= neg_in;
      sat_ff      <= sat_in;
      low_ff      <= low_in;
      rsh_ff      <= rsh_in;
      prod_ff     <= prod_in;
      fdig_ff     <= fdig_in;
      work_ff     <= work_in;
      wbuf_ff     <= wbuf_in;
      fbuf_ff     <= fbuf_in;
      wi_ff       <= wi_in;
      fi_ff       <= fi_in;
      keep_ff     <= keep_in;
      found_ff    <= found_in;
      cnt_ff      <= cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule
